// ===== src/lsfs_pkg.sv =====
// Shared types, constants and microcode encodings for the LED strip frame serializer.
package lsfs_pkg;

    // Build constants
    localparam int MODULE_LEDS   = 8;
    localparam int LED_COUNT     = MODULE_LEDS + 1;
    localparam int LED_PTR_W     = $clog2(LED_COUNT);
    localparam int START_BYTES   = 4;
    localparam int MAX_END_BYTES = 8;
    localparam int CNT_W         = $clog2(MAX_END_BYTES);

    localparam logic [7:0] HEADER_MARK = 8'hE0;
    localparam logic [7:0] ZERO_BYTE   = 8'h00;
    localparam logic [7:0] ONES_BYTE   = 8'hFF;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_BRIGHTNESS   = 2'd0,
        REG_MODULE_COUNT = 2'd1,
        REG_END_BYTES    = 2'd2
    } reg_index_t;

    // Item operations
    typedef enum logic [1:0] {
        OP_WRITE_MODULE = 2'd0,
        OP_WRITE_STATUS = 2'd1,
        OP_REFRESH      = 2'd2
    } op_t;

    typedef struct packed {
        logic [1:0] operation;
        logic [3:0] led_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } cmd_t;

    typedef struct packed {
        logic [7:0] spi_byte;
        logic       last;
    } result_t;

    // Microcode steps
    typedef enum logic [2:0] {
        STEP_IDLE  = 3'd0,
        STEP_START = 3'd1,
        STEP_HDR   = 3'd2,
        STEP_BLUE  = 3'd3,
        STEP_GREEN = 3'd4,
        STEP_RED   = 3'd5,
        STEP_END   = 3'd6
    } step_t;

    typedef enum logic [1:0] {
        COND_ALWAYS   = 2'd0,
        COND_GO       = 2'd1,
        COND_CNT_NZ   = 2'd2,
        COND_LED_LOOP = 2'd3
    } cond_t;

    typedef enum logic [2:0] {
        SRC_ZERO   = 3'd0,
        SRC_HEADER = 3'd1,
        SRC_BLUE   = 3'd2,
        SRC_GREEN  = 3'd3,
        SRC_RED    = 3'd4,
        SRC_ONES   = 3'd5
    } src_t;

    typedef enum logic [1:0] {
        CNT_HOLD       = 2'd0,
        CNT_LOAD_START = 2'd1,
        CNT_LOAD_ENDS  = 2'd2,
        CNT_DEC        = 2'd3
    } cnt_op_t;

    typedef enum logic [1:0] {
        LED_HOLD  = 2'd0,
        LED_CLEAR = 2'd1,
        LED_INC   = 2'd2
    } led_op_t;

    typedef struct packed {
        cond_t   cond;
        step_t   next_true;
        step_t   next_false;
        logic    emit;
        src_t    src;
        cnt_op_t cnt_op;
        led_op_t led_op;
    } ucode_t;

    // Sequencer to datapath
    typedef struct packed {
        logic    busy;
        logic    emit;
        logic    last;
        src_t    src;
        led_op_t led_op;
    } seq_ctrl_t;

    // Datapath to sequencer
    typedef struct packed {
        logic             go;
        logic             more_leds;
        logic             ends_nz;
        logic [CNT_W-1:0] ends_m1;
    } seq_stat_t;

endpackage

// ===== src/lsfs_sequencer.sv =====
// Microcode ROM, step counter and loop counter that drive the serializer datapath.
module lsfs_sequencer
    import lsfs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  seq_stat_t stat,
    output seq_ctrl_t ctrl
);

    // Control store: one word per step
    function automatic ucode_t rom(input step_t s);
        ucode_t w;
        w = '{cond: COND_ALWAYS, next_true: STEP_IDLE, next_false: STEP_IDLE,
              emit: 1'b0, src: SRC_ZERO, cnt_op: CNT_HOLD, led_op: LED_HOLD};
        unique case (s)
            STEP_IDLE:
                w = '{cond: COND_GO, next_true: STEP_START, next_false: STEP_IDLE,
                      emit: 1'b0, src: SRC_ZERO, cnt_op: CNT_LOAD_START,
                      led_op: LED_CLEAR};
            STEP_START:
                w = '{cond: COND_CNT_NZ, next_true: STEP_START, next_false: STEP_HDR,
                      emit: 1'b1, src: SRC_ZERO, cnt_op: CNT_DEC, led_op: LED_HOLD};
            STEP_HDR:
                w = '{cond: COND_ALWAYS, next_true: STEP_BLUE, next_false: STEP_BLUE,
                      emit: 1'b1, src: SRC_HEADER, cnt_op: CNT_HOLD, led_op: LED_HOLD};
            STEP_BLUE:
                w = '{cond: COND_ALWAYS, next_true: STEP_GREEN, next_false: STEP_GREEN,
                      emit: 1'b1, src: SRC_BLUE, cnt_op: CNT_HOLD, led_op: LED_HOLD};
            STEP_GREEN:
                w = '{cond: COND_ALWAYS, next_true: STEP_RED, next_false: STEP_RED,
                      emit: 1'b1, src: SRC_GREEN, cnt_op: CNT_HOLD, led_op: LED_HOLD};
            STEP_RED:
                w = '{cond: COND_LED_LOOP, next_true: STEP_HDR, next_false: STEP_END,
                      emit: 1'b1, src: SRC_RED, cnt_op: CNT_LOAD_ENDS, led_op: LED_INC};
            STEP_END:
                w = '{cond: COND_CNT_NZ, next_true: STEP_END, next_false: STEP_IDLE,
                      emit: 1'b1, src: SRC_ONES, cnt_op: CNT_DEC, led_op: LED_HOLD};
            default:
                w = '{cond: COND_ALWAYS, next_true: STEP_IDLE, next_false: STEP_IDLE,
                      emit: 1'b0, src: SRC_ZERO, cnt_op: CNT_HOLD, led_op: LED_HOLD};
        endcase
        return w;
    endfunction

    step_t            step_reg, step_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    ucode_t           uw;
    logic             take;

    assign uw = rom(step_reg);

    // Branch condition and next step
    always_comb
    begin
        unique case (uw.cond)
            COND_ALWAYS:   take = 1'b1;
            COND_GO:       take = stat.go;
            COND_CNT_NZ:   take = (cnt_reg != '0);
            COND_LED_LOOP: take = stat.more_leds;
            default:       take = 1'b0;
        endcase

        if (take)
            step_next = uw.next_true;
        else if (uw.cond == COND_LED_LOOP && !stat.ends_nz)
            step_next = STEP_IDLE;  // no end bytes: run closes on the red byte
        else
            step_next = uw.next_false;
    end

    // Loop counter
    always_comb
    begin
        unique case (uw.cnt_op)
            CNT_HOLD:       cnt_next = cnt_reg;
            CNT_LOAD_START: cnt_next = CNT_W'(START_BYTES - 1);
            CNT_LOAD_ENDS:  cnt_next = stat.ends_m1;
            CNT_DEC:        cnt_next = cnt_reg - 1'b1;
            default:        cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_IDLE;
            cnt_reg  <= '0;
        end
        else
        begin
            step_reg <= step_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Control out
    assign ctrl.busy   = (step_reg != STEP_IDLE);
    assign ctrl.emit   = uw.emit;
    assign ctrl.last   = uw.emit && (step_next == STEP_IDLE);
    assign ctrl.src    = uw.src;
    assign ctrl.led_op = uw.led_op;

endmodule

// ===== src/lsfs_datapath.sv =====
// Colour store, refresh flag, LED pointer and byte output register.
module lsfs_datapath
    import lsfs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  cmd_t                 cmd,
    input  logic [4:0]           brightness,
    input  logic [3:0]           used_modules,
    input  logic [3:0]           end_count,
    input  seq_ctrl_t            ctrl,
    output seq_stat_t            stat,
    output result_t              result,
    output logic                 result_valid
);

    logic [23:0]          store_reg [LED_COUNT];
    logic                 dirty_reg, dirty_next;
    logic [LED_PTR_W-1:0] led_ptr_reg, led_ptr_next;
    logic [7:0]           byte_reg, byte_next;
    logic                 last_reg;
    logic                 valid_reg;

    logic                 accept;
    logic                 wr_module, wr_status;
    logic [LED_PTR_W-1:0] wr_addr;
    logic [23:0]          rd_entry;

    assign accept    = start && !ctrl.busy;
    assign wr_module = accept && (cmd.operation == OP_WRITE_MODULE)
                       && (cmd.led_index < used_modules);
    assign wr_status = accept && (cmd.operation == OP_WRITE_STATUS);
    assign wr_addr   = wr_status ? '0 : LED_PTR_W'({1'b0, cmd.led_index} + 5'd1);

    // Status for the sequencer
    assign stat.go        = accept && (cmd.operation == OP_REFRESH) && dirty_reg;
    assign stat.more_leds = ({{(8-LED_PTR_W){1'b0}}, led_ptr_reg} != {4'd0, used_modules});
    assign stat.ends_nz   = (end_count != '0);
    assign stat.ends_m1   = CNT_W'(end_count - 4'd1);

    // Colour store, entry 0 is the status LED
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LED_COUNT; i++)
                store_reg[i] <= '0;
        end
        else if (wr_module || wr_status)
        begin
            store_reg[wr_addr] <= {cmd.red, cmd.green, cmd.blue};
        end
    end

    // Refresh flag and LED pointer
    always_comb
    begin
        dirty_next = dirty_reg;
        if (wr_module || wr_status)
            dirty_next = 1'b1;
        else if (stat.go)
            dirty_next = 1'b0;

        case (ctrl.led_op)
            LED_CLEAR: led_ptr_next = '0;
            LED_INC:   led_ptr_next = led_ptr_reg + 1'b1;
            default:   led_ptr_next = led_ptr_reg;
        endcase
    end

    assign rd_entry = store_reg[led_ptr_reg];

    // Byte select
    always_comb
    begin
        case (ctrl.src)
            SRC_ZERO:   byte_next = ZERO_BYTE;
            SRC_HEADER: byte_next = HEADER_MARK | {3'b000, brightness};
            SRC_BLUE:   byte_next = rd_entry[7:0];
            SRC_GREEN:  byte_next = rd_entry[15:8];
            SRC_RED:    byte_next = rd_entry[23:16];
            SRC_ONES:   byte_next = ONES_BYTE;
            default:    byte_next = ZERO_BYTE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dirty_reg   <= 1'b1;
            led_ptr_reg <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            dirty_reg   <= dirty_next;
            led_ptr_reg <= led_ptr_next;
            valid_reg   <= ctrl.emit;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= ctrl.last;
    end

    assign result.spi_byte = byte_reg;
    assign result.last     = last_reg;
    assign result_valid    = valid_reg;

endmodule

// ===== src/led_strip_frame_serializer_top.sv =====
// Top level of the LED strip frame serializer: configuration registers and unit wiring.
//
// An item is taken when start is high and busy is low. Write items (status LED or
// module LED) leave busy low. A refresh item with the store dirty starts the
// microcode run: busy is high while it lasts, one stream byte per cycle, set by the
// sequencer stepping through its control store. Each byte sits on result for one
// cycle with result_valid high; the receiver must take it then, as the block cannot
// be stalled. A refresh with the store clean emits nothing. Configuration writes
// through cfg_write are taken at once and belong to idle periods.
module led_strip_frame_serializer_top
    import lsfs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  cmd_t       cmd,
    output result_t    result,
    output logic       result_valid,
    input  logic       cfg_write,
    input  logic [1:0] cfg_index,
    input  logic [4:0] cfg_data
);

    logic [4:0] brightness_reg;
    logic [3:0] module_count_reg;
    logic [3:0] end_bytes_reg;
    logic [3:0] used_modules;
    logic [3:0] end_count;
    seq_ctrl_t  ctrl;
    seq_stat_t  stat;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg   <= 5'd31;
            module_count_reg <= 4'd0;
            end_bytes_reg    <= 4'd4;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_BRIGHTNESS:   brightness_reg   <= cfg_data;
                REG_MODULE_COUNT: module_count_reg <= cfg_data[3:0];
                REG_END_BYTES:    end_bytes_reg    <= cfg_data[3:0];
                default:          ;
            endcase
        end
    end

    // Clamp counts to what the store and frame allow
    assign used_modules = (module_count_reg > 4'(MODULE_LEDS)) ? 4'(MODULE_LEDS)
                                                               : module_count_reg;
    assign end_count    = (end_bytes_reg > 4'(MAX_END_BYTES)) ? 4'(MAX_END_BYTES)
                                                              : end_bytes_reg;

    lsfs_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    lsfs_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .cmd          (cmd),
        .brightness   (brightness_reg),
        .used_modules (used_modules),
        .end_count    (end_count),
        .ctrl         (ctrl),
        .stat         (stat),
        .result       (result),
        .result_valid (result_valid)
    );

    assign busy = ctrl.busy;

endmodule

// ===== tb/led_strip_frame_serializer_top_test.sv =====
// Self-checking testbench for the LED strip frame serializer: directed and random items.
`timescale 1ns / 100ps

module led_strip_frame_serializer_top_test;
    import lsfs_pkg::*;

    // Operation and register codes that the package leaves unnamed
    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES      = 6;
    localparam int RANDOM_PHASES      = 10;
    localparam int ITEMS_PER_PHASE    = 29;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       start;
    logic       busy;
    cmd_t       cmd;
    result_t    result;
    logic       result_valid;
    logic       cfg_write;
    logic [1:0] cfg_index;
    logic [4:0] cfg_data;

    // Mirror of the block: color store, refresh flag and registers
    logic [7:0] led_red   [LED_COUNT];
    logic [7:0] led_green [LED_COUNT];
    logic [7:0] led_blue  [LED_COUNT];
    logic       store_dirty;
    logic [4:0] brightness_q;
    logic [3:0] module_count_q;
    logic [3:0] end_bytes_q;

    result_t expected_bytes[$];
    int      mismatch_count = 0;
    bit      burst_mode     = 1'b0;

    led_strip_frame_serializer_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .result      (result),
        .result_valid(result_valid),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("ERROR t=%0t: %s", $time, what);
        mismatch_count++;
    endtask

    function automatic int active_modules();
        return (module_count_q > MODULE_LEDS) ? MODULE_LEDS : int'(module_count_q);
    endfunction

    function automatic int end_count();
        return (end_bytes_q > MAX_END_BYTES) ? MAX_END_BYTES : int'(end_bytes_q);
    endfunction

    task automatic reset_mirror();
        for (int i = 0; i < LED_COUNT; i++)
        begin
            led_red[i]   = 8'h00;
            led_green[i] = 8'h00;
            led_blue[i]  = 8'h00;
        end
        store_dirty    = 1'b1;
        brightness_q   = 5'd31;
        module_count_q = 4'd0;
        end_bytes_q    = 4'd4;
    endtask

    task automatic queue_byte(input logic [7:0] b);
        result_t r;
        r.spi_byte = b;
        r.last     = 1'b0;
        expected_bytes.push_back(r);
    endtask

    // Apply one accepted item to the mirror and queue the stream it produces
    task automatic predict_stream(input cmd_t c);
        int slot;
        slot = int'(c.led_index) + 1;
        case (c.operation)
            OP_WRITE_MODULE:
            begin
                if (int'(c.led_index) < active_modules())
                begin
                    led_red[slot]   = c.red;
                    led_green[slot] = c.green;
                    led_blue[slot]  = c.blue;
                    store_dirty     = 1'b1;
                end
            end
            OP_WRITE_STATUS:
            begin
                led_red[0]   = c.red;
                led_green[0] = c.green;
                led_blue[0]  = c.blue;
                store_dirty  = 1'b1;
            end
            OP_REFRESH:
            begin
                if (store_dirty)
                begin
                    for (int i = 0; i < START_BYTES; i++)
                        queue_byte(ZERO_BYTE);
                    for (int i = 0; i <= active_modules(); i++)
                    begin
                        queue_byte(HEADER_MARK | {3'b000, brightness_q});
                        queue_byte(led_blue[i]);
                        queue_byte(led_green[i]);
                        queue_byte(led_red[i]);
                    end
                    for (int i = 0; i < end_count(); i++)
                        queue_byte(ONES_BYTE);
                    expected_bytes[expected_bytes.size() - 1].last = 1'b1;
                    store_dirty = 1'b0;
                end
            end
            default: ;
        endcase
    endtask

    // Gap after an item: mostly none or short, now and then long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 9);
        if (burst_mode || roll < 6)
            return 0;
        if (roll < 9)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // Present one item at a falling edge and hold it until taken
    task automatic send_item(input cmd_t c);
        int gap;
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_stream(c);
        @(negedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    function automatic cmd_t make_cmd(input logic [1:0] op, input logic [3:0] idx,
                                      input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] b);
        cmd_t c;
        c.operation = op;
        c.led_index = idx;
        c.red       = r;
        c.green     = g;
        c.blue      = b;
        return c;
    endfunction

    // Drop start, drain the stream and let the block go quiet
    task automatic settle();
        start <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Register write while idle; mirror follows at once
    task automatic write_reg(input logic [1:0] idx, input logic [4:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
        case (idx)
            REG_BRIGHTNESS:   brightness_q   = data;
            REG_MODULE_COUNT: module_count_q = data[3:0];
            REG_END_BYTES:    end_bytes_q    = data[3:0];
            default: ;
        endcase
    endtask

    task automatic write_config(input logic [4:0] bright, input logic [4:0] count,
                                input logic [4:0] ends);
        write_reg(REG_BRIGHTNESS, bright);
        write_reg(REG_MODULE_COUNT, count);
        write_reg(REG_END_BYTES, ends);
    endtask

    // Stream right after reset: black status LED, reset registers
    task automatic test_reset_stream();
        send_item(make_cmd(OP_REFRESH, 4'h0, 8'h00, 8'h00, 8'h00));
        settle();
    endtask

    // Clean refresh, unused operation and a module write with no modules in use
    task automatic test_quiet_items();
        send_item(make_cmd(OP_REFRESH, 4'hF, 8'hFF, 8'hFF, 8'hFF));
        send_item(make_cmd(OP_UNUSED, 4'h5, 8'h12, 8'h34, 8'h56));
        send_item(make_cmd(OP_WRITE_MODULE, 4'h0, 8'hFF, 8'hFF, 8'hFF));
        send_item(make_cmd(OP_REFRESH, 4'h0, 8'h00, 8'h00, 8'h00));
        settle();
    endtask

    task automatic test_status_write();
        send_item(make_cmd(OP_WRITE_STATUS, 4'hA, 8'hFF, 8'h00, 8'hAA));
        send_item(make_cmd(OP_REFRESH, 4'h0, 8'h00, 8'h00, 8'h00));
        settle();
    endtask

    // Index bounds at full and partial module counts, with no end bytes and then one
    task automatic test_module_bounds();
        write_config(5'd0, 5'd8, 5'd0);
        send_item(make_cmd(OP_WRITE_MODULE, 4'd0, 8'hFF, 8'hFF, 8'hFF));
        send_item(make_cmd(OP_WRITE_MODULE, 4'd7, 8'h01, 8'h80, 8'h5A));
        send_item(make_cmd(OP_WRITE_MODULE, 4'd8, 8'hEE, 8'hEE, 8'hEE));
        send_item(make_cmd(OP_WRITE_MODULE, 4'd15, 8'hDD, 8'hDD, 8'hDD));
        send_item(make_cmd(OP_REFRESH, 4'd0, 8'h00, 8'h00, 8'h00));
        send_item(make_cmd(OP_WRITE_STATUS, 4'd0, 8'h00, 8'hFF, 8'h00));
        send_item(make_cmd(OP_REFRESH, 4'd0, 8'h00, 8'h00, 8'h00));
        settle();
        write_config(5'd31, 5'd3, 5'd1);
        send_item(make_cmd(OP_WRITE_MODULE, 4'd2, 8'h55, 8'hAA, 8'h0F));
        send_item(make_cmd(OP_WRITE_MODULE, 4'd3, 8'h66, 8'h66, 8'h66));
        send_item(make_cmd(OP_REFRESH, 4'd0, 8'h00, 8'h00, 8'h00));
        settle();
    endtask

    // Counts above the limits saturate; unused register index is a no-op
    task automatic test_register_saturation();
        write_config(5'h15, 5'h1F, 5'd15);
        write_reg(REG_UNUSED, 5'h1F);
        send_item(make_cmd(OP_WRITE_MODULE, 4'd3, 8'hC3, 8'h3C, 8'h99));
        send_item(make_cmd(OP_REFRESH, 4'd0, 8'h00, 8'h00, 8'h00));
        send_item(make_cmd(OP_REFRESH, 4'd0, 8'h00, 8'h00, 8'h00));
        settle();
        write_config(5'd10, 5'd9, 5'd9);
        send_item(make_cmd(OP_WRITE_STATUS, 4'd0, 8'h80, 8'h40, 8'h20));
        send_item(make_cmd(OP_REFRESH, 4'd0, 8'h00, 8'h00, 8'h00));
        settle();
    endtask

    function automatic logic [4:0] pick_count();
        case ($urandom_range(0, 4))
            0: return 5'd0;
            1: return 5'd1;
            2: return 5'd8;
            default: return 5'($urandom_range(0, 31));
        endcase
    endfunction

    // Random phases: module writes mostly in range, mixed with status writes, refreshes and unused operations
    task automatic test_random_phases();
        cmd_t c;
        int   sent;
        int   roll;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            burst_mode = (phase % 4 == 3);
            case (phase)
                0: write_config(5'd0, 5'd8, 5'd8);
                1: write_config(5'd31, 5'd0, 5'd0);
                default: write_config(5'($urandom_range(0, 31)), pick_count(), pick_count());
            endcase
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                c = make_cmd(2'($urandom), 4'($urandom), 8'($urandom), 8'($urandom),
                             8'($urandom));
                roll = $urandom_range(0, 99);
                if (roll < 45)
                begin
                    c.operation = OP_WRITE_MODULE;
                    if (active_modules() > 0 && $urandom_range(0, 4) != 0)
                        c.led_index = 4'($urandom_range(0, active_modules() - 1));
                end
                else if (roll < 60)
                    c.operation = OP_WRITE_STATUS;
                else if (roll < 92)
                    c.operation = OP_REFRESH;
                else
                    c.operation = OP_UNUSED;
                sent++;
                send_item(c);
            end
            settle();
        end
        burst_mode = 1'b0;
    endtask

    // Stream checker: every strobe is compared with the oldest expected byte
    always @(posedge clk)
    begin : check_stream
        result_t want;
        if (rst_n && result_valid)
        begin
            if (expected_bytes.size() == 0)
                report_mismatch($sformatf("unexpected byte %02h last %0b",
                                          result.spi_byte, result.last));
            else
            begin
                want = expected_bytes.pop_front();
                if (result.spi_byte !== want.spi_byte)
                    report_mismatch($sformatf("spi_byte exp %02h got %02h",
                                              want.spi_byte, result.spi_byte));
                if (result.last !== want.last)
                    report_mismatch($sformatf("last exp %0b got %0b (byte %02h)",
                                              want.last, result.last, want.spi_byte));
            end
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        cmd       = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        reset_mirror();
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_stream();
        test_quiet_items();
        test_status_write();
        test_module_bounds();
        test_register_saturation();
        test_random_phases();

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
